### rtl/hsv2rgb_pkg.sv
// Shared types, constants and helper functions for the HSV to RGB converter.
// Used by every module of the pipeline; depends on nothing.
`default_nettype none

package hsv2rgb_pkg;

  localparam int FRAC_BITS = 16;
  localparam int IN_FRAC   = 16;
  localparam int IN_W      = IN_FRAC + 2;
  localparam int Q_W       = FRAC_BITS + 1;
  localparam int HUE_W     = 16;

  localparam logic [Q_W-1:0]     ONE_Q  = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [IN_FRAC:0]   IN_ONE = {1'b1, {IN_FRAC{1'b0}}};

  typedef enum logic [2:0] {
    SEC_RY = 3'd0,
    SEC_YG = 3'd1,
    SEC_GC = 3'd2,
    SEC_CB = 3'd3,
    SEC_BM = 3'd4,
    SEC_MR = 3'd5
  } sector_t;

  typedef struct packed {
    logic [Q_W-1:0]       sat;
    logic [Q_W-1:0]       val;
    sector_t              sector;
    logic [FRAC_BITS-1:0] frac;
    logic [7:0]           alpha;
  } prep_t;

  typedef struct packed {
    logic [Q_W-1:0] val;
    logic [Q_W-1:0] p;
    logic [Q_W-1:0] q;
    logic [Q_W-1:0] t;
    sector_t        sector;
    logic [7:0]     alpha;
  } terms_t;

  function automatic logic [Q_W-1:0] clamp_unit(input logic [IN_W-1:0] raw);
    logic [IN_FRAC:0]           lim;
    logic [IN_FRAC+FRAC_BITS:0] wide;
    if (raw[IN_W-1]) begin
      lim = '0;
    end else if (raw[IN_FRAC:0] > IN_ONE) begin
      lim = IN_ONE;
    end else begin
      lim = raw[IN_FRAC:0];
    end
    wide = {lim, {FRAC_BITS{1'b0}}};
    return wide[IN_FRAC+FRAC_BITS:IN_FRAC];
  endfunction

  function automatic logic [FRAC_BITS-1:0] hue_to_q(input logic [HUE_W-1:0] hue);
    logic [HUE_W+FRAC_BITS-1:0] wide;
    wide = {hue, {FRAC_BITS{1'b0}}};
    return wide[HUE_W+FRAC_BITS-1:HUE_W];
  endfunction

  function automatic logic [7:0] to_byte(input logic [Q_W-1:0] x);
    logic [Q_W+7:0] m;
    m = {x, 8'b0} - {8'b0, x};
    return m[FRAC_BITS+7:FRAC_BITS];
  endfunction

endpackage

`default_nettype wire

### rtl/hsv2rgb_prep.sv
// First pipeline stage: clamps saturation and brightness and splits hue into sector and fraction.
// Depends on hsv2rgb_pkg.
`default_nettype none

module hsv2rgb_prep
  import hsv2rgb_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic [HUE_W-1:0]        hue,
  input  wire logic signed [IN_W-1:0]  saturation,
  input  wire logic signed [IN_W-1:0]  brightness,
  input  wire logic [7:0]              alpha,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output prep_t                        out_data
);

  logic [FRAC_BITS-1:0] hq;
  logic [FRAC_BITS+2:0] h6;
  prep_t                data_next;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    hq = hue_to_q(hue);
    h6 = {1'b0, hq, 2'b0} + {2'b0, hq, 1'b0};
    data_next.sat    = clamp_unit(saturation);
    data_next.val    = clamp_unit(brightness);
    data_next.sector = sector_t'(h6[FRAC_BITS+2:FRAC_BITS]);
    data_next.frac   = h6[FRAC_BITS-1:0];
    data_next.alpha  = alpha;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= data_next;
    end
  end

endmodule

`default_nettype wire

### rtl/hsv2rgb_terms.sv
// Second and third pipeline stages: form s*f, s*(1-f) and p, then q and t.
// Depends on hsv2rgb_pkg.
`default_nettype none

module hsv2rgb_terms
  import hsv2rgb_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  wire prep_t in_data,
  output logic       out_valid,
  input  wire logic  out_ready,
  output terms_t     out_data
);

  logic             mid_valid;
  logic             mid_ready;
  logic [Q_W-1:0]   mid_val;
  logic [Q_W-1:0]   mid_p;
  logic [Q_W-1:0]   mid_sf;
  logic [Q_W-1:0]   mid_s1f;
  sector_t          mid_sector;
  logic [7:0]       mid_alpha;

  logic [Q_W-1:0]   one_minus_f;
  logic [2*Q_W-1:0] sf_prod;
  logic [2*Q_W-1:0] s1f_prod;
  logic [2*Q_W-1:0] p_prod;
  logic [2*Q_W-1:0] q_prod;
  logic [2*Q_W-1:0] t_prod;

  assign mid_ready = !out_valid || out_ready;
  assign in_ready  = !mid_valid || mid_ready;

  always_comb begin
    one_minus_f = ONE_Q - {1'b0, in_data.frac};
    sf_prod     = {{Q_W{1'b0}}, in_data.sat} * {{(Q_W+1){1'b0}}, in_data.frac};
    s1f_prod    = {{Q_W{1'b0}}, in_data.sat} * {{Q_W{1'b0}}, one_minus_f};
    p_prod      = {{Q_W{1'b0}}, in_data.val} * {{Q_W{1'b0}}, ONE_Q - in_data.sat};
    q_prod      = {{Q_W{1'b0}}, mid_val} * {{Q_W{1'b0}}, ONE_Q - mid_sf};
    t_prod      = {{Q_W{1'b0}}, mid_val} * {{Q_W{1'b0}}, ONE_Q - mid_s1f};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        mid_valid <= in_valid;
      end
      if (mid_ready) begin
        out_valid <= mid_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      mid_val    <= in_data.val;
      mid_p      <= p_prod[FRAC_BITS+Q_W-1:FRAC_BITS];
      mid_sf     <= sf_prod[FRAC_BITS+Q_W-1:FRAC_BITS];
      mid_s1f    <= s1f_prod[FRAC_BITS+Q_W-1:FRAC_BITS];
      mid_sector <= in_data.sector;
      mid_alpha  <= in_data.alpha;
    end
    if (mid_ready && mid_valid) begin
      out_data.val    <= mid_val;
      out_data.p      <= mid_p;
      out_data.q      <= q_prod[FRAC_BITS+Q_W-1:FRAC_BITS];
      out_data.t      <= t_prod[FRAC_BITS+Q_W-1:FRAC_BITS];
      out_data.sector <= mid_sector;
      out_data.alpha  <= mid_alpha;
    end
  end

endmodule

`default_nettype wire

### rtl/hsv2rgb_pack.sv
// Last pipeline stage: places v, p, q and t by sector and scales each channel to a byte.
// Depends on hsv2rgb_pkg.
`default_nettype none

module hsv2rgb_pack
  import hsv2rgb_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   in_valid,
  output logic        in_ready,
  input  wire terms_t in_data,
  output logic        out_valid,
  input  wire logic   out_ready,
  output logic [7:0]  red,
  output logic [7:0]  green,
  output logic [7:0]  blue,
  output logic [7:0]  alpha_out
);

  logic [Q_W-1:0] r_sel;
  logic [Q_W-1:0] g_sel;
  logic [Q_W-1:0] b_sel;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    case (in_data.sector)
      SEC_RY: begin
        r_sel = in_data.val; g_sel = in_data.t;   b_sel = in_data.p;
      end
      SEC_YG: begin
        r_sel = in_data.q;   g_sel = in_data.val; b_sel = in_data.p;
      end
      SEC_GC: begin
        r_sel = in_data.p;   g_sel = in_data.val; b_sel = in_data.t;
      end
      SEC_CB: begin
        r_sel = in_data.p;   g_sel = in_data.q;   b_sel = in_data.val;
      end
      SEC_BM: begin
        r_sel = in_data.t;   g_sel = in_data.p;   b_sel = in_data.val;
      end
      default: begin
        r_sel = in_data.val; g_sel = in_data.p;   b_sel = in_data.q;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      red       <= to_byte(r_sel);
      green     <= to_byte(g_sel);
      blue      <= to_byte(b_sel);
      alpha_out <= in_data.alpha;
    end
  end

endmodule

`default_nettype wire

### rtl/hsv_to_rgb_converter.sv
// Top level of the HSV to RGB converter: four register stages, one pixel per clock.
// An accepted pixel passes through the prep, terms mid, terms out and pack registers in order.
// Throughput is one pixel per cycle; each stage holds its item while the next one is full.
// Reset (rst, synchronous) clears the stage valid bits only; the data registers are not reset.
// Depends on hsv2rgb_pkg, hsv2rgb_prep, hsv2rgb_terms and hsv2rgb_pack.
`default_nettype none

module hsv_to_rgb_converter
  import hsv2rgb_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [HUE_W-1:0]       hue,
  input  wire logic signed [IN_W-1:0] saturation,
  input  wire logic signed [IN_W-1:0] brightness,
  input  wire logic [7:0]             alpha,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [7:0]                  red,
  output logic [7:0]                  green,
  output logic [7:0]                  blue,
  output logic [7:0]                  alpha_out
);

  logic   prep_valid;
  logic   prep_ready;
  prep_t  prep_data;
  logic   terms_valid;
  logic   terms_ready;
  terms_t terms_data;

  hsv2rgb_prep u_prep (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .hue        (hue),
    .saturation (saturation),
    .brightness (brightness),
    .alpha      (alpha),
    .out_valid  (prep_valid),
    .out_ready  (prep_ready),
    .out_data   (prep_data)
  );

  hsv2rgb_terms u_terms (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (prep_valid),
    .in_ready  (prep_ready),
    .in_data   (prep_data),
    .out_valid (terms_valid),
    .out_ready (terms_ready),
    .out_data  (terms_data)
  );

  hsv2rgb_pack u_pack (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (terms_valid),
    .in_ready  (terms_ready),
    .in_data   (terms_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .red       (red),
    .green     (green),
    .blue      (blue),
    .alpha_out (alpha_out)
  );

  a_reset_empties: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  a_ready_chain: assert property (@(posedge clk) disable iff (rst) out_ready |-> in_ready)
    else $error("input stalled while output side accepts");

  a_stall_source: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled without a stalled output transfer");

endmodule

`default_nettype wire

### tb/tb_hsv_to_rgb_converter.sv
// Self-checking testbench for hsv_to_rgb_converter: directed clamp and sector-edge pixels,
// then random pixel streams under sender bursts and receiver stalls, checked in order.
// Depends on hsv2rgb_pkg and the converter RTL.
module tb_hsv_to_rgb_converter;
  timeunit 1ns;
  timeprecision 1ps;

  import hsv2rgb_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 16;
  localparam int MAX_PRINTED  = 40;
  localparam logic [63:0] UNIT = 64'd65536;

  typedef struct packed {
    logic [HUE_W-1:0]       hue;
    logic signed [IN_W-1:0] saturation;
    logic signed [IN_W-1:0] brightness;
    logic [7:0]             alpha;
  } pixel_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } rgba_t;

  typedef struct packed {
    pixel_t px;
    rgba_t  want;
  } pending_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [HUE_W-1:0]       hue = '0;
  logic signed [IN_W-1:0] saturation = '0;
  logic signed [IN_W-1:0] brightness = '0;
  logic [7:0]             alpha = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [7:0]             red;
  logic [7:0]             green;
  logic [7:0]             blue;
  logic [7:0]             alpha_out;

  pending_t pending_rgba_q[$];
  int       err_count = 0;
  int       sent_count = 0;
  int       directed_count = 0;
  int       checked_count = 0;
  int       burst_left = 0;
  int       gap_max = 0;
  int       cycle_count = 0;

  hsv_to_rgb_converter dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .hue        (hue),
    .saturation (saturation),
    .brightness (brightness),
    .alpha      (alpha),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .red        (red),
    .green      (green),
    .blue       (blue),
    .alpha_out  (alpha_out)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [63:0] unit_level(input logic signed [IN_W-1:0] raw);
    logic [63:0] lvl;
    if (raw[IN_W-1]) begin
      return '0;
    end
    lvl = {{(64-IN_W){1'b0}}, raw};
    if (lvl > UNIT) begin
      lvl = UNIT;
    end
    return lvl;
  endfunction

  function automatic logic [7:0] chan_byte(input logic [63:0] x);
    logic [63:0] scaled;
    scaled = (x * 64'd255) >> 16;
    return scaled[7:0];
  endfunction

  function automatic rgba_t hsv_to_rgba(input pixel_t px);
    logic [63:0] s, v, h6, f, p, q, t, r, g, b;
    sector_t     sec;
    rgba_t       res;
    s   = unit_level(px.saturation);
    v   = unit_level(px.brightness);
    h6  = {48'b0, px.hue} * 64'd6;
    sec = sector_t'(h6[18:16]);
    f   = {48'b0, h6[15:0]};
    p   = (v * (UNIT - s)) >> 16;
    q   = (v * (UNIT - ((s * f) >> 16))) >> 16;
    t   = (v * (UNIT - ((s * (UNIT - f)) >> 16))) >> 16;
    case (sec)
      SEC_RY: begin r = v; g = t; b = p; end
      SEC_YG: begin r = q; g = v; b = p; end
      SEC_GC: begin r = p; g = v; b = t; end
      SEC_CB: begin r = p; g = q; b = v; end
      SEC_BM: begin r = t; g = p; b = v; end
      default: begin r = v; g = p; b = q; end
    endcase
    res.red   = chan_byte(r);
    res.green = chan_byte(g);
    res.blue  = chan_byte(b);
    res.alpha = px.alpha;
    return res;
  endfunction

  function automatic pixel_t make_pixel(input int h, input int s, input int b, input int a);
    pixel_t px;
    px.hue        = HUE_W'(h);
    px.saturation = IN_W'(s);
    px.brightness = IN_W'(b);
    px.alpha      = 8'(a);
    return px;
  endfunction

  function automatic logic [IN_W-1:0] random_level();
    case ($urandom_range(9))
      0: return {1'b1, 17'($urandom)};
      1: return IN_W'($urandom_range(65537, 131071));
      2: return IN_W'($urandom);
      3: return ($urandom_range(1) == 0) ? IN_W'(0) : IN_W'(65536);
      default: return IN_W'($urandom_range(0, 65536));
    endcase
  endfunction

  function automatic pixel_t random_pixel();
    pixel_t px;
    px.hue        = HUE_W'($urandom);
    px.saturation = random_level();
    px.brightness = random_level();
    px.alpha      = 8'($urandom);
    return px;
  endfunction

  task automatic report_mismatch(input string msg);
    if (err_count < MAX_PRINTED) begin
      $display("ERROR %0t ns: %s", $realtime, msg);
    end
    err_count++;
  endtask

  task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want,
                             input pixel_t px);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %0d expected %0d (hue=%h sat=%h bri=%h alpha=%h)",
                                name, got, want, px.hue, px.saturation, px.brightness,
                                px.alpha));
    end
  endtask

  // Called at a rising edge; returns at the edge where the transfer happened.
  task automatic send_pixel(input pixel_t px);
    hue        <= px.hue;
    saturation <= px.saturation;
    brightness <= px.brightness;
    alpha      <= px.alpha;
    in_valid   <= 1'b1;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    pending_rgba_q.push_back('{px: px, want: hsv_to_rgba(px)});
    sent_count++;
  endtask

  task automatic idle_cycles(input int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic pace_sender();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 24);
      idle_cycles($urandom_range(0, gap_max));
    end
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (pending_rgba_q.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic test_clamp_extremes();
    send_pixel(make_pixel(0, 0, 65536, 'hA5));
    send_pixel(make_pixel(0, 65536, 65536, 'h00));
    send_pixel(make_pixel('hFFFF, 65536, 65536, 'hFF));
    send_pixel(make_pixel('hFFFF, 'h1FFFF, 'h1FFFF, 'h5A));
    send_pixel(make_pixel('h8000, 'h20000, 'h20000, 'h3C));
    send_pixel(make_pixel('h1234, 'h3FFFF, 'h3FFFF, 'hC3));
    send_pixel(make_pixel('h4000, 65537, 65537, 'h81));
    send_pixel(make_pixel('h2AAA, 65536, 0, 'h7E));
    send_pixel(make_pixel('h5555, 'h0FFFF, 'h0FFFF, 'h18));
    directed_count += 9;
  endtask

  task automatic test_sector_edges();
    int edges[12] = '{1, 10922, 10923, 21845, 21846, 32767, 32768, 43690, 43691,
                      54613, 54614, 65535};
    foreach (edges[i]) begin
      send_pixel(make_pixel(edges[i], (i % 2 == 0) ? 65536 : 'h9000, 'hC000 + i, i * 21));
    end
    directed_count += 12;
  endtask

  task automatic test_bursty_stream(input int n);
    gap_max = 6;
    repeat (n) begin
      send_pixel(random_pixel());
      pace_sender();
    end
  endtask

  task automatic test_drain_pause(input int n);
    repeat (2) begin
      repeat (n) begin
        send_pixel(random_pixel());
      end
      wait_for_results();
    end
  endtask

  task automatic test_full_rate_stream(input int n);
    gap_max = 0;
    repeat (n) begin
      send_pixel(random_pixel());
      pace_sender();
    end
  endtask

  always @(posedge clk) begin : check_results
    pending_t head;
    if (!rst && out_valid && out_ready) begin
      if (pending_rgba_q.size() == 0) begin
        report_mismatch($sformatf("unexpected transfer rgb=%h %h %h alpha=%h",
                                  red, green, blue, alpha_out));
      end else begin
        head = pending_rgba_q.pop_front();
        check_field("red", red, head.want.red, head.px);
        check_field("green", green, head.want.green, head.px);
        check_field("blue", blue, head.want.blue, head.px);
        check_field("alpha_out", alpha_out, head.want.alpha, head.px);
        checked_count++;
      end
    end
  end

  always @(posedge clk) begin
    case (cycle_count[10:9])
      2'd0: out_ready <= 1'b1;
      2'd1: out_ready <= 1'($urandom_range(1));
      2'd2: out_ready <= (cycle_count[1:0] != 2'd3);
      default: out_ready <= ($urandom_range(3) == 0);
    endcase
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL hsv_to_rgb_converter");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_clamp_extremes();
    test_sector_edges();
    test_bursty_stream(525);
    test_drain_pause(30);
    test_full_rate_stream(450);
    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d pixels (%0d directed at clamp limits and sector edges), checked %0d.",
             sent_count, directed_count, checked_count);
    $display("Random pixels ran with sender bursts, full-rate streams and receiver stalls.");
    if (err_count == 0 && pending_rgba_q.size() == 0) begin
      $display("PASS hsv_to_rgb_converter");
    end else begin
      $display("FAIL hsv_to_rgb_converter");
    end
    $finish;
  end

endmodule
